FILE: src/afl_pkg.sv
// shared types and constants of the failed-login lockout table
package afl_pkg;

  // default table geometry
  localparam int NUM_ENTRIES_DEF = 1024;
  localparam int COUNT_BITS_DEF  = 16;

  // fixed field widths
  localparam int TIME_W     = 32;
  localparam int IDX_W      = 10;
  localparam int LIMIT_W    = 8;
  localparam int SRV_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 40;

  // attempt budget is the user limit times this factor
  localparam int ATTEMPT_SCALE = 2;
  localparam int ATT_W         = LIMIT_W + 1;
  localparam int SHARE_W       = ATT_W + 1;
  localparam int DIV_STEPS     = ATT_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVER_COUNT = 1'b0,
    CFG_SYNC_SITE    = 1'b1
  } cfg_reg_t;

  // item operation codes
  typedef enum logic [0:0] {
    OP_FAILURE = 1'b0,
    OP_QUERY   = 1'b1
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } afl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic take_item;
    logic rd_issue;
    logic eval;
    logic div_run;
    logic emit;
  } afl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic op_query;
    logic div_done;
    logic out_blocked;
  } afl_sts_t;

endpackage

FILE: src/afl_ram.sv
// generic simple dual-port ram with registered read
module afl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/afl_ctrl.sv
// controller state machine of the lockout table
module afl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  afl_pkg::afl_sts_t  sts,
  output afl_pkg::afl_cmd_t  cmd
);

  import afl_pkg::*;

  afl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.op_query ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_blocked) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/afl_dp.sv
// datapath: item registers, table memory, share divider and result register
module afl_dp #(
  parameter int NUM_ENTRIES = afl_pkg::NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = afl_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  afl_pkg::afl_cmd_t               cmd,
  output afl_pkg::afl_sts_t               sts,
  input  logic [afl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            cfg_we,
  input  logic [afl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [afl_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  import afl_pkg::*;

  localparam int AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int MEM_W = COUNT_BITS + TIME_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [SRV_W-1:0] server_count;
  logic             is_sync_site;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SRV_W'(1);
      is_sync_site <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SERVER_COUNT: server_count <= cfg_data[SRV_W-1:0];
        CFG_SYNC_SITE:    is_sync_site <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // held input item
  op_t                op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  lock_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_q    <= op_t'(s_axis_tuser);
      idx_q   <= s_axis_tdata[9:0];
      now_q   <= s_axis_tdata[41:10];
      lock_q  <= s_axis_tdata[73:42];
      limit_q <= s_axis_tdata[81:74];
    end
  end

  // entry 0 and entries past the table hold no record
  logic [31:0]   idx_wide;
  logic          slot_ok;
  logic [AW-1:0] item_addr;

  assign idx_wide  = 32'(idx_q);
  assign slot_ok   = (idx_q != '0) && (idx_wide < 32'(NUM_ENTRIES));
  assign item_addr = idx_wide[AW-1:0];

  // clearing sweep address
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // table memory: count above time
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [MEM_W-1:0] wr_data;
  logic [MEM_W-1:0] rd_data;
  logic [COUNT_BITS-1:0] cnt_next;

  assign wr_en   = cmd.clr_wr || (cmd.eval && (op_q == OP_FAILURE) && slot_ok);
  assign wr_addr = cmd.clr_wr ? clr_addr : item_addr;
  assign wr_data = cmd.clr_wr ? '0 : {cnt_next, now_q};

  afl_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (item_addr),
    .rd_data (rd_data)
  );

  // evaluate the stored record
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [TIME_W-1:0]     rd_last;
  logic [TIME_W-1:0]     end_sum;
  logic                  passed;

  assign rd_cnt  = slot_ok ? rd_data[MEM_W-1:TIME_W] : '0;
  assign rd_last = slot_ok ? rd_data[TIME_W-1:0] : '0;
  assign end_sum = rd_last + lock_q;
  assign passed  = (lock_q != '0) && (end_sum < now_q);

  // failure update: restart after the window, else saturating increment
  always_comb begin
    if (passed) begin
      cnt_next = COUNT_BITS'(1);
    end else if (rd_cnt == CNT_MAX) begin
      cnt_next = CNT_MAX;
    end else begin
      cnt_next = rd_cnt + COUNT_BITS'(1);
    end
  end

  logic [COUNT_BITS-1:0] cnt_q;
  logic [TIME_W-1:0]     end_q;
  logic                  passed_q;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cnt_q    <= rd_cnt;
      end_q    <= end_sum;
      passed_q <= passed;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [SRV_W-1:0]     divisor;
  logic [ATT_W-1:0]     div_q;
  logic [SRV_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SRV_W:0]       trial;
  logic                 trial_ge;

  assign divisor  = (server_count == '0) ? SRV_W'(1) : server_count;
  assign trial    = {rem_q, div_q[ATT_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.eval) begin
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      div_q <= ATT_W'(limit_q) * ATT_W'(ATTEMPT_SCALE);
      rem_q <= '0;
    end else if (cmd.div_run) begin
      div_q <= {div_q[ATT_W-2:0], trial_ge};
      rem_q <= trial_ge ? SRV_W'(trial - {1'b0, divisor}) : SRV_W'(trial);
    end
  end

  // this server's share and the lock decision
  logic [SHARE_W-1:0] share;
  logic               res_locked;
  logic               res_indef;
  logic [TIME_W-1:0]  res_time;

  assign share = SHARE_W'(div_q) + (is_sync_site ? SHARE_W'(rem_q) : SHARE_W'(0));

  always_comb begin
    res_locked = 1'b0;
    res_indef  = 1'b0;
    res_time   = '0;
    if (limit_q != '0) begin
      if (share == '0) begin
        res_locked = 1'b1;
        res_indef  = 1'b1;
      end else if ((32'(cnt_q) < 32'(share)) || passed_q) begin
        res_locked = 1'b0;
      end else if (lock_q == '0) begin
        res_locked = 1'b1;
        res_indef  = 1'b1;
      end else begin
        res_locked = 1'b1;
        res_time   = end_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {6'b0, res_time, res_indef, res_locked};
    end
  end

  // status back to the controller
  assign sts.clr_last    = (clr_addr == AW'(NUM_ENTRIES - 1));
  assign sts.op_query    = (op_q == OP_QUERY);
  assign sts.div_done    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_blocked = m_axis_tvalid && !m_axis_tready;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // item updates never touch the no-record entry
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !cmd.clr_wr) |-> (wr_addr != '0))
    else $error("write to entry zero");

  // the divider stops at its last step
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_run && sts.div_done) |=> !cmd.div_run)
    else $error("divider ran past its last step");

endmodule

FILE: src/auth_failure_lockout_table_unit.sv
// top level of the failed-login lockout table
//
// channel  direction  handshake               payload
// s_axis   in         tvalid/tready           tuser operation, tdata index/time/lock/limit
// m_axis   out        tvalid/tready           tdata locked/indefinite/unlock_time
// cfg      in         cfg_we                  cfg_index, cfg_data
//
// a failure item passes through accept, memory read, then evaluate and write back
// a query item passes through accept, read, evaluate, the share divider, then emit
// after reset a clearing pass writes zeros to all NUM_ENTRIES entries; no item is taken then
// the result register lets the block finish the next failure item while a result waits
// a query waits in its emit step while the previous result is still not taken
module auth_failure_lockout_table_unit #(
  parameter int NUM_ENTRIES = afl_pkg::NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = afl_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, now_seconds, lock_time, attempt_limit, zero pad
  input  logic [afl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // locked, indefinite, unlock_time, zero pad
  output logic [afl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [afl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import afl_pkg::*;

  afl_cmd_t cmd;
  afl_sts_t sts;

  // sequencer
  afl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // table, divider and result register
  afl_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: dv/auth_failure_lockout_table_unit_test.sv
// self-checking stream testbench for the failed-login lockout table
module auth_failure_lockout_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import afl_pkg::*;

  localparam int NUM_SLOTS = NUM_ENTRIES_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_SAT = '1;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRESSURE_HOLD = 400;
  localparam int BURST_FAILURES = 20;

  // one login event as carried on the input stream
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  now_s;
    logic [TIME_W-1:0]  lock_s;
    logic [LIMIT_W-1:0] limit;
  } login_item_t;

  // lock status as carried on the output stream
  typedef struct packed {
    logic              locked;
    logic              indefinite;
    logic [TIME_W-1:0] unlock_time;
  } lock_status_t;

  typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

  // directed row: an item or a register setting, with an optional typed answer
  typedef struct packed {
    row_kind_t        kind;
    login_item_t      item;
    logic [SRV_W-1:0] servers;
    logic             sync_site;
    logic             typed;
    lock_status_t     want;
  } step_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // entry_index, now_seconds, lock_time, attempt_limit, zero pad
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // operation
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // locked, indefinite, unlock_time, zero pad
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the table and registers
  logic [COUNT_BITS_DEF-1:0] fail_count_tbl [NUM_SLOTS];
  logic [TIME_W-1:0]         fail_time_tbl [NUM_SLOTS];
  logic [SRV_W-1:0]          cur_servers = 5'd1;
  logic                      cur_sync_site = 1'b1;

  lock_status_t status_q [$];
  lock_status_t got_status, want_status;
  step_row_t    directed_rows [$];

  int errors = 0;
  int items_sent = 0;
  int failures_sent = 0;
  int status_checked = 0;
  int locked_seen = 0;
  int indefinite_seen = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;

  // random traffic shaping
  logic [TIME_W-1:0] clock_s;
  logic [TIME_W-1:0] phase_lock;
  logic [IDX_W-1:0]  hot_entries [4];

  auth_failure_lockout_table_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // table update and lock decision; returns 1 when the item yields a status
  function automatic bit predict_lockout(input login_item_t it, output lock_status_t res);
    bit                        slot_ok;
    logic [COUNT_BITS_DEF-1:0] cnt;
    logic [TIME_W-1:0]         last_t;
    logic [TIME_W-1:0]         window_end;
    logic                      passed;
    logic [SRV_W-1:0]          srv;
    logic [ATT_W-1:0]          budget;
    logic [SHARE_W-1:0]        share;
    slot_ok = (it.idx != '0);
    cnt = slot_ok ? fail_count_tbl[it.idx] : '0;
    last_t = slot_ok ? fail_time_tbl[it.idx] : '0;
    window_end = last_t + it.lock_s;
    passed = (it.lock_s != '0) && (window_end < it.now_s);
    res = '0;
    if (it.op == OP_FAILURE) begin
      if (slot_ok) begin
        fail_count_tbl[it.idx] = passed ? COUNT_BITS_DEF'(1) :
                                 ((cnt == COUNT_SAT) ? cnt : cnt + COUNT_BITS_DEF'(1));
        fail_time_tbl[it.idx] = it.now_s;
      end
      return 1'b0;
    end
    if (it.limit != '0) begin
      srv = (cur_servers == '0) ? 5'd1 : cur_servers;
      budget = {it.limit, 1'b0};
      share = SHARE_W'(budget / srv);
      if (cur_sync_site) share = share + SHARE_W'(budget % srv);
      if (share == '0) begin
        res.locked = 1'b1;
        res.indefinite = 1'b1;
      end else if (cnt < share || passed) begin
        res.locked = 1'b0;
      end else if (it.lock_s == '0) begin
        res.locked = 1'b1;
        res.indefinite = 1'b1;
      end else begin
        res.locked = 1'b1;
        res.unlock_time = window_end;
      end
    end
    return 1'b1;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int tx_gap();
    return ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
  endfunction

  // mostly plausible login traffic on a few hot entries, rest raw noise
  function automatic login_item_t gen_item();
    login_item_t it;
    if ($urandom_range(0, 99) < 25) begin
      it.op = op_t'($urandom_range(0, 1));
      it.idx = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
      it.now_s = $urandom;
      it.lock_s = $urandom;
      it.limit = LIMIT_W'($urandom_range(0, 255));
    end else begin
      clock_s = clock_s + $urandom_range(0, 15);
      it.op = ($urandom_range(0, 99) < 55) ? OP_FAILURE : OP_QUERY;
      it.idx = hot_entries[$urandom_range(0, 3)];
      it.now_s = clock_s;
      it.lock_s = ($urandom_range(0, 9) == 0) ? '0 : phase_lock;
      it.limit = LIMIT_W'($urandom_range(1, 4));
    end
    return it;
  endfunction

  // present one item, wait for the handshake, record what it should give
  task automatic offer_item(input login_item_t it, input int gap, input bit typed,
                            input lock_status_t want);
    lock_status_t res;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {{(S_TDATA_W - IDX_W - 2 * TIME_W - LIMIT_W){1'b0}},
                     it.limit, it.lock_s, it.now_s, it.idx};
    s_axis_tuser <= it.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (it.op == OP_FAILURE) failures_sent++;
    if (predict_lockout(it, res)) status_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // let every pending status drain and the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [SRV_W-1:0] servers, input logic sync_site);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SERVER_COUNT;
    cfg_data <= servers;
    @(negedge clk);
    cfg_index <= CFG_SYNC_SITE;
    cfg_data <= {{(CFG_DATA_W - 1){1'b0}}, sync_site};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_servers = servers;
    cur_sync_site = sync_site;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = idle_len();
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // compare each status with the oldest expectation
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_status.locked = m_axis_tdata[0];
      got_status.indefinite = m_axis_tdata[1];
      got_status.unlock_time = m_axis_tdata[2 +: TIME_W];
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: status with none expected: expected nothing, actual %h",
                 $time, got_status);
      end else begin
        want_status = status_q.pop_front();
        status_checked++;
        if (got_status.locked) locked_seen++;
        if (got_status.indefinite) indefinite_seen++;
        if (got_status.locked !== want_status.locked) begin
          errors++;
          $display("%0t: locked: expected %b, actual %b",
                   $time, want_status.locked, got_status.locked);
        end
        if (got_status.indefinite !== want_status.indefinite) begin
          errors++;
          $display("%0t: indefinite: expected %b, actual %b",
                   $time, want_status.indefinite, got_status.indefinite);
        end
        if (got_status.unlock_time !== want_status.unlock_time) begin
          errors++;
          $display("%0t: unlock_time: expected %h, actual %h",
                   $time, want_status.unlock_time, got_status.unlock_time);
        end
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin
    login_item_t         it;
    logic [SRV_W-1:0]    phase_srv [6];
    logic                phase_sync [6];
    foreach (fail_count_tbl[i]) begin
      fail_count_tbl[i] = '0;
      fail_time_tbl[i] = '0;
    end
    phase_srv = '{5'd1, 5'd20, 5'd31, 5'd0, 5'd2, SRV_W'($urandom_range(0, 31))};
    phase_sync = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1))};

    directed_rows = '{
      // fresh table reads unlocked
      '{ROW_ITEM, '{OP_QUERY, 10'd5, 32'd100, 32'd10, 8'd3}, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      // no limit
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'd0, 32'd0, 8'd0}, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      // entry zero is never written
      '{ROW_ITEM, '{OP_FAILURE, 10'd0, 32'd50, 32'd0, 8'd255}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'd60, 32'd0, 8'd1}, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      // two failures inside the window lock a limit of one
      '{ROW_ITEM, '{OP_FAILURE, 10'd7, 32'd1000, 32'd100, 8'd0}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_FAILURE, 10'd7, 32'd1000, 32'd100, 8'd0}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd1050, 32'd100, 8'd1}, '0, 1'b0, 1'b1,
        '{1'b1, 1'b0, 32'd1100}},
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd1050, 32'd0, 8'd1}, '0, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd0}},
      // window passed
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd2000, 32'd100, 8'd1}, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{ROW_ITEM, '{OP_FAILURE, 10'd7, 32'd2000, 32'd100, 8'd0}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd2000, 32'd100, 8'd255}, '0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'd0}},
      // unlock time wraps to zero and still reads locked
      '{ROW_ITEM, '{OP_FAILURE, 10'd1023, 32'hFFFF_FFF0, 32'd0, 8'd0}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_FAILURE, 10'd1023, 32'hFFFF_FFF0, 32'd0, 8'd0}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd1023, 32'd0, 32'h10, 8'd1}, '0, 1'b0, 1'b1, '{1'b1, 1'b0, 32'd0}},
      '{ROW_ITEM, '{OP_QUERY, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1}, '0, 1'b0, 1'b0, '0},
      // zero share locks for good
      '{ROW_CONFIG, '0, 5'd20, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd2000, 32'd100, 8'd1}, '0, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd0}},
      '{ROW_ITEM, '{OP_QUERY, 10'd1023, 32'd0, 32'h10, 8'd255}, '0, 1'b0, 1'b0, '0},
      // server count zero acts as one
      '{ROW_CONFIG, '0, 5'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd1023, 32'd0, 32'h10, 8'd1}, '0, 1'b0, 1'b0, '0},
      // largest server count with remainder
      '{ROW_CONFIG, '0, 5'd31, 1'b1, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd7, 32'd2000, 32'd100, 8'd255}, '0, 1'b0, 1'b0, '0},
      '{ROW_CONFIG, '0, 5'd1, 1'b1, 1'b0, '0},
      // alternating bit patterns
      '{ROW_ITEM, '{OP_FAILURE, 10'd512, 32'hAAAA_AAAA, 32'h5555_5555, 8'hAA}, '0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, '{OP_QUERY, 10'd512, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55}, '0, 1'b0, 1'b0, '0}
    };

    // reset, then the table clears itself before taking items
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed rows
    rx_stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        set_config(directed_rows[i].servers, directed_rows[i].sync_site);
      end else begin
        offer_item(directed_rows[i].item, $urandom_range(0, 2), directed_rows[i].typed,
                   directed_rows[i].want);
      end
    end

    // back to back failures on one entry, then a query of it
    rx_stall_pct = 0;
    it = '{OP_FAILURE, 10'd3, 32'd500, 32'd0, 8'd0};
    repeat (BURST_FAILURES) offer_item(it, 0, 1'b0, '0);
    it = '{OP_QUERY, 10'd3, 32'd600, 32'd0, 8'd255};
    offer_item(it, 0, 1'b0, '0);

    // random phases, one register setting each
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      set_config(phase_srv[ph], phase_sync[ph]);
      tx_gap_pct = (ph == 0) ? 0 : 15 + 10 * ph;
      rx_stall_pct = (ph == 0) ? 0 : 10 + 8 * ph;
      clock_s = (ph == 3) ? 32'hFFFF_FE00 : $urandom;
      phase_lock = $urandom_range(5, 60);
      foreach (hot_entries[k]) hot_entries[k] = IDX_W'($urandom_range(1, NUM_SLOTS - 1));
      if (ph == 4) hot_entries[0] = '0;
      // long receiver hold-off while queries keep coming
      if (ph == 2) begin
        rx_hold_req = PRESSURE_HOLD;
        repeat (24) begin
          it = gen_item();
          it.op = OP_QUERY;
          offer_item(it, 0, 1'b0, '0);
        end
      end
      repeat (65) offer_item(gen_item(), tx_gap(), 1'b0, '0);
    end

    wait_idle();
    $display("run: %0d items (%0d failures), %0d status results compared",
             items_sent, failures_sent, status_checked);
    $display("run: %0d locked, %0d indefinite, across six register settings plus a burst",
             locked_seen, indefinite_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
